// ----- sv/tspd_pkg.sv -----
// shared types and constants for the touchscreen packet decoder
package tspd_pkg;

    localparam int PACKET_BYTES = 10;
    localparam int IDX_W        = 4;

    // packet format codes
    localparam logic [1:0] PROTO_TEN   = 2'd0;
    localparam logic [1:0] PROTO_SIX   = 2'd1;
    localparam logic [1:0] PROTO_FOUR  = 2'd2;
    localparam logic [1:0] PROTO_THREE = 2'd3;

    // result kinds
    localparam logic [1:0] EV_REPORT   = 2'd0;
    localparam logic [1:0] EV_ACK      = 2'd1;
    localparam logic [1:0] EV_RESPONSE = 2'd2;

    // request kinds
    localparam logic ACT_BYTE    = 1'b0;
    localparam logic ACT_COMMAND = 1'b1;

    localparam logic [7:0] CHK_SEED   = 8'haa;
    localparam logic [7:0] CH_LEAD    = 8'h55; // 'U'
    localparam logic [7:0] CH_TOUCH   = 8'h54; // 'T'
    localparam logic [7:0] CH_ACK     = 8'h41; // 'A'
    localparam logic [7:0] CH_ZERO    = 8'h30; // '0'
    localparam logic [7:0] CH_LOWER_A = 8'h61; // 'a'
    localparam logic [7:0] CH_LOWER_Z = 8'h7a; // 'z'
    localparam logic [7:0] CASE_GAP   = 8'h20;

    localparam int TDATA_IN_W  = 16;
    localparam int TDATA_OUT_W = 120;

    typedef struct packed {
        logic [1:0]  event_kind;
        logic        has_xy;
        logic [15:0] x_pos;
        logic [15:0] y_pos;
        logic        has_pressure;
        logic [15:0] pressure;
        logic        has_touch;
        logic        touch;
        logic        sync;
        logic        ack_ok;
        logic [63:0] response_data;
    } t_result;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
        logic [7:0] command_code;
    } t_request;

endpackage

// ----- sv/tspd_in_reg.sv -----
// input register holding one request ahead of the decoder
module tspd_in_reg
    import tspd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_request i_req,
    output logic     o_valid,
    input  logic     i_advance,
    output t_request o_req
);

    logic     r_valid;
    t_request r_req;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
    end

endmodule

// ----- sv/tspd_decode.sv -----
// framing state, packet store and per-byte decode
module tspd_decode
    import tspd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_wdata,
    input  logic       i_advance,
    input  t_request   i_req,
    output logic       o_has_result,
    output t_result    o_result
);

    logic [1:0]       r_protocol;
    logic [IDX_W-1:0] r_byte_index;
    logic [7:0]       r_running_sum;
    logic [7:0]       r_expected_type;
    logic [7:0]       r_store [PACKET_BYTES];

    logic [IDX_W-1:0] n_byte_index;
    logic [7:0]       n_running_sum;
    logic [7:0]       n_expected_type;
    logic [IDX_W-1:0] w_idx;
    logic             w_store_we;

    always_comb begin
        logic [7:0] b;
        logic [7:0] c;
        b = i_req.rx_byte;
        c = i_req.command_code;
        o_has_result    = 1'b0;
        o_result        = '0;
        n_byte_index    = r_byte_index;
        n_running_sum   = r_running_sum;
        n_expected_type = r_expected_type;
        w_idx           = r_byte_index;
        w_store_we      = 1'b0;

        if (i_req.action == ACT_COMMAND) begin
            if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
                n_expected_type = c - CASE_GAP;
            end else begin
                n_expected_type = c;
            end
        end else begin
            w_store_we = 1'b1;
            case (r_protocol)
                PROTO_TEN: begin
                    if (r_byte_index >= IDX_W'(PACKET_BYTES)) begin
                        w_idx = '0;
                    end
                    n_byte_index = w_idx + IDX_W'(1);
                    n_running_sum = r_running_sum + b;
                    if (w_idx == '0) begin
                        n_running_sum = CHK_SEED + b;
                        if (b != CH_LEAD) begin
                            n_byte_index = '0;
                        end
                    end else if (w_idx == IDX_W'(PACKET_BYTES - 1)) begin
                        n_byte_index = '0;
                        if (b == r_running_sum && r_store[1] == r_expected_type) begin
                            o_has_result = 1'b1;
                            if (r_store[1] == CH_TOUCH) begin
                                o_result.event_kind = EV_REPORT;
                                o_result.has_xy     = 1'b1;
                                o_result.x_pos      = {r_store[4], r_store[3]};
                                o_result.y_pos      = {r_store[6], r_store[5]};
                                if (r_store[2][7]) begin
                                    o_result.has_pressure = 1'b1;
                                    o_result.pressure     = {r_store[8], r_store[7]};
                                end
                                o_result.has_touch = 1'b1;
                                o_result.touch     = |r_store[2][1:0];
                                o_result.sync      = 1'b1;
                            end else if (r_store[1] == CH_ACK) begin
                                o_result.event_kind = EV_ACK;
                                if (r_store[2] == CH_ZERO) begin
                                    n_expected_type = CH_TOUCH;
                                    o_result.ack_ok = 1'b1;
                                end
                            end else begin
                                o_result.event_kind    = EV_RESPONSE;
                                o_result.response_data = {r_store[8], r_store[7], r_store[6],
                                                          r_store[5], r_store[4], r_store[3],
                                                          r_store[2], r_store[1]};
                                n_expected_type = CH_ACK;
                            end
                        end
                    end
                end
                PROTO_SIX, PROTO_FOUR: begin
                    if (r_byte_index > IDX_W'(5)) begin
                        w_idx = '0;
                    end
                    n_byte_index = w_idx + IDX_W'(1);
                    case (w_idx)
                        IDX_W'(0): if (b[7:6] != 2'b11) n_byte_index = '0;
                        IDX_W'(1): if (b[7:6] != 2'b10) n_byte_index = '0;
                        IDX_W'(2): if (b[7:6] != 2'b01) n_byte_index = '0;
                        IDX_W'(3): begin
                            if (b[7:6] != 2'b00) begin
                                n_byte_index = '0;
                            end else begin
                                o_has_result    = 1'b1;
                                o_result.has_xy = 1'b1;
                                o_result.x_pos  = {4'b0, r_store[0][5:0], r_store[1][5:0]};
                                o_result.y_pos  = {4'b0, r_store[2][5:0], b[5:0]};
                                if (r_protocol == PROTO_FOUR) begin
                                    o_result.has_touch = 1'b1;
                                    o_result.touch     = 1'b1;
                                    o_result.sync      = 1'b1;
                                    n_byte_index       = '0;
                                end
                            end
                        end
                        IDX_W'(4): begin
                            if (b != 8'd0) begin
                                o_has_result  = 1'b1;
                                o_result.sync = 1'b1;
                                n_byte_index  = '0;
                            end
                        end
                        default: begin
                            // status byte closes the frame
                            if (b[7:4] == 4'd0) begin
                                o_result.has_pressure = 1'b1;
                                o_result.pressure     = {8'd0, b};
                                o_result.has_touch    = 1'b1;
                                o_result.touch        = |b;
                            end
                            o_has_result  = 1'b1;
                            o_result.sync = 1'b1;
                            n_byte_index  = '0;
                        end
                    endcase
                end
                default: begin
                    if (r_byte_index > IDX_W'(2)) begin
                        w_idx = '0;
                    end
                    n_byte_index = w_idx + IDX_W'(1);
                    if (w_idx == '0) begin
                        if (b[6:0] != 7'h01) begin
                            n_byte_index = '0;
                        end
                    end else if (w_idx == IDX_W'(2)) begin
                        o_has_result       = 1'b1;
                        o_result.has_touch = 1'b1;
                        o_result.touch     = !r_store[1][7];
                        o_result.has_xy    = 1'b1;
                        o_result.x_pos     = {8'd0, r_store[1]};
                        o_result.y_pos     = {8'd0, b};
                        o_result.sync      = 1'b1;
                        n_byte_index       = '0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_protocol      <= PROTO_TEN;
            r_byte_index    <= '0;
            r_running_sum   <= '0;
            r_expected_type <= CH_TOUCH;
        end else if (i_cfg_we) begin
            r_protocol    <= i_cfg_wdata;
            r_byte_index  <= '0;
            r_running_sum <= '0;
        end else if (i_advance) begin
            r_byte_index    <= n_byte_index;
            r_running_sum   <= n_running_sum;
            r_expected_type <= n_expected_type;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && w_store_we) begin
            r_store[w_idx] <= i_req.rx_byte;
        end
    end

endmodule

// ----- sv/tspd_out_reg.sv -----
// result register on the master side
module tspd_out_reg
    import tspd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_valid,
    output logic    o_free,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ----- sv/touchscreen_serial_packet_decoder_top.sv -----
// touchscreen serial packet decoder, top level
//
//  channel  | direction | tdata                              | tuser
//  s_axis   | in        | rx_byte, command_code              | action
//  m_axis   | out       | report / ack / response fields     | event_kind
//  cfg      | in        | protocol (write enable, no index)  | -
//
// one request a cycle sustained while the result register has room; input register then
// decode into the result register. the decode path is byte compares,
// the ten-byte sum check and a fixed select from the packet store.
// reset is synchronous, active low; it restores the ten-byte format, expected type 'T'.
// a request that gives no result passes even while the output stalls.
module touchscreen_serial_packet_decoder_top
    import tspd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TDATA_IN_W-1:0]  s_axis_tdata,  // rx_byte, command_code
    input  logic                   s_axis_tuser,  // action
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,  // has_xy, x_pos, y_pos, has_pressure,
                                                  // pressure, has_touch, touch, sync,
                                                  // ack_ok, response_data, pad
    output logic [1:0]             m_axis_tuser   // event_kind
);

    t_request w_in_req;
    t_request w_req;
    t_result  w_result;
    t_result  w_out;
    logic     w_req_valid;
    logic     w_has_result;
    logic     w_out_free;
    logic     w_advance;

    assign w_in_req.action       = s_axis_tuser;
    assign w_in_req.rx_byte      = s_axis_tdata[7:0];
    assign w_in_req.command_code = s_axis_tdata[15:8];

    // a request moves on when it gives nothing or the result register has room
    assign w_advance = w_req_valid && (!w_has_result || w_out_free);

    tspd_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_req     (w_in_req),
        .o_valid   (w_req_valid),
        .i_advance (w_advance),
        .o_req     (w_req)
    );

    tspd_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_advance    (w_advance),
        .i_req        (w_req),
        .o_has_result (w_has_result),
        .o_result     (w_result)
    );

    tspd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance && w_has_result),
        .i_result (w_result),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_free   (w_out_free),
        .o_result (w_out)
    );

    assign m_axis_tuser = w_out.event_kind;
    assign m_axis_tdata = {2'b00, w_out.response_data, w_out.ack_ok, w_out.sync,
                           w_out.touch, w_out.has_touch, w_out.pressure,
                           w_out.has_pressure, w_out.y_pos, w_out.x_pos, w_out.has_xy};

endmodule

// ----- verif/touchscreen_serial_packet_decoder_top_tb.sv -----
// self-checking testbench for the touchscreen serial packet decoder
`timescale 1ns / 1ps

module touchscreen_serial_packet_decoder_top_tb;
    import tspd_pkg::*;

    localparam logic [7:0] CH_UPPER_Z = 8'h5a; // 'Z'
    localparam int         DRAIN      = 8;
    localparam int         HOLD_LONG  = 80;

    // expected-report tracker: mirrors the deframing state and queues due results
    class touch_report_board;
        logic [1:0] fmt;
        logic [3:0] idx;
        logic [7:0] sum;
        logic [7:0] frame [PACKET_BYTES];
        logic [7:0] want_type;
        t_result    due_reports[$];
        int         errors;

        function new();
            fmt       = PROTO_TEN;
            idx       = '0;
            sum       = '0;
            want_type = CH_TOUCH;
            errors    = 0;
            foreach (frame[k]) frame[k] = '0;
        endfunction

        function void set_format(logic [1:0] p);
            fmt = p;
            idx = '0;
            sum = '0;
        endfunction

        function bit deframe_ten(logic [7:0] b, inout t_result res);
            logic [3:0] at;
            logic [3:0] nxt;
            bit         hit;
            hit = 1'b0;
            at  = idx;
            if (at >= PACKET_BYTES) at = '0;
            frame[at] = b;
            nxt = at + 4'd1;
            if (at == 0) begin
                sum = CHK_SEED;
                if (b != CH_LEAD) nxt = '0;
            end else if (at == PACKET_BYTES - 1) begin
                nxt = '0;
                if (b == sum && frame[1] == want_type) begin
                    hit = 1'b1;
                    if (frame[1] == CH_TOUCH) begin
                        res.event_kind = EV_REPORT;
                        res.has_xy     = 1'b1;
                        res.x_pos      = {frame[4], frame[3]};
                        res.y_pos      = {frame[6], frame[5]};
                        if (frame[2][7]) begin
                            res.has_pressure = 1'b1;
                            res.pressure     = {frame[8], frame[7]};
                        end
                        res.has_touch = 1'b1;
                        res.touch     = |frame[2][1:0];
                        res.sync      = 1'b1;
                    end else if (frame[1] == CH_ACK) begin
                        res.event_kind = EV_ACK;
                        if (frame[2] == CH_ZERO) begin
                            want_type  = CH_TOUCH;
                            res.ack_ok = 1'b1;
                        end
                    end else begin
                        res.event_kind    = EV_RESPONSE;
                        res.response_data = {frame[8], frame[7], frame[6], frame[5],
                                             frame[4], frame[3], frame[2], frame[1]};
                        want_type         = CH_ACK;
                    end
                end
            end
            sum = sum + b;
            idx = nxt;
            return hit;
        endfunction

        function bit deframe_six(logic [7:0] b, bit four, inout t_result res);
            logic [3:0] at;
            logic [3:0] nxt;
            bit         hit;
            hit = 1'b0;
            at  = idx;
            if (at > 5) at = '0;
            frame[at] = b;
            nxt = at + 4'd1;
            case (at)
                0: if (b[7:6] != 2'b11) nxt = '0;
                1: if (b[7:6] != 2'b10) nxt = '0;
                2: if (b[7:6] != 2'b01) nxt = '0;
                3: begin
                    if (b[7:6] != 2'b00) begin
                        nxt = '0;
                    end else begin
                        res.has_xy = 1'b1;
                        res.x_pos  = {4'd0, frame[0][5:0], frame[1][5:0]};
                        res.y_pos  = {4'd0, frame[2][5:0], frame[3][5:0]};
                        if (four) begin
                            res.has_touch = 1'b1;
                            res.touch     = 1'b1;
                            res.sync      = 1'b1;
                            nxt           = '0;
                        end
                        hit = 1'b1;
                    end
                end
                4: begin
                    // a nonzero status byte closes the frame early
                    if (b != 0) begin
                        res.sync = 1'b1;
                        nxt      = '0;
                        hit      = 1'b1;
                    end
                end
                default: begin
                    if (b[7:4] == 4'd0) begin
                        res.has_pressure = 1'b1;
                        res.pressure     = {8'd0, b};
                        res.has_touch    = 1'b1;
                        res.touch        = |b;
                    end
                    res.sync = 1'b1;
                    nxt      = '0;
                    hit      = 1'b1;
                end
            endcase
            idx = nxt;
            return hit;
        endfunction

        function bit deframe_three(logic [7:0] b, inout t_result res);
            logic [3:0] at;
            logic [3:0] nxt;
            bit         hit;
            hit = 1'b0;
            at  = idx;
            if (at > 2) at = '0;
            frame[at] = b;
            nxt = at + 4'd1;
            if (at == 0) begin
                if (b[6:0] != 7'h01) nxt = '0;
            end else if (at == 2) begin
                res.has_touch = 1'b1;
                res.touch     = ~frame[1][7];
                res.has_xy    = 1'b1;
                res.x_pos     = {8'd0, frame[1]};
                res.y_pos     = {8'd0, frame[2]};
                res.sync      = 1'b1;
                nxt           = '0;
                hit           = 1'b1;
            end
            idx = nxt;
            return hit;
        endfunction

        function void note_request(t_request r);
            t_result    res;
            bit         hit;
            logic [7:0] c;
            res = '0;
            if (r.action == ACT_COMMAND) begin
                c = r.command_code;
                if (c >= CH_LOWER_A && c <= CH_LOWER_Z) c = c - CASE_GAP;
                want_type = c;
                return;
            end
            case (fmt)
                PROTO_TEN:  hit = deframe_ten(r.rx_byte, res);
                PROTO_SIX:  hit = deframe_six(r.rx_byte, 1'b0, res);
                PROTO_FOUR: hit = deframe_six(r.rx_byte, 1'b1, res);
                default:    hit = deframe_three(r.rx_byte, res);
            endcase
            if (hit) due_reports.push_back(res);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            if (errors < 60)
                $display("mismatch in %s: got %0h, expected %0h", what, got, want);
            errors++;
        endtask

        task check_result(t_result got);
            t_result want;
            if (due_reports.size() == 0) begin
                report("unexpected result, event_kind", 64'(got.event_kind), '0);
                return;
            end
            want = due_reports.pop_front();
            if (got.event_kind != want.event_kind)
                report("event_kind", 64'(got.event_kind), 64'(want.event_kind));
            if (got.has_xy != want.has_xy)
                report("has_xy", 64'(got.has_xy), 64'(want.has_xy));
            if (got.x_pos != want.x_pos)
                report("x_pos", 64'(got.x_pos), 64'(want.x_pos));
            if (got.y_pos != want.y_pos)
                report("y_pos", 64'(got.y_pos), 64'(want.y_pos));
            if (got.has_pressure != want.has_pressure)
                report("has_pressure", 64'(got.has_pressure), 64'(want.has_pressure));
            if (got.pressure != want.pressure)
                report("pressure", 64'(got.pressure), 64'(want.pressure));
            if (got.has_touch != want.has_touch)
                report("has_touch", 64'(got.has_touch), 64'(want.has_touch));
            if (got.touch != want.touch)
                report("touch", 64'(got.touch), 64'(want.touch));
            if (got.sync != want.sync)
                report("sync", 64'(got.sync), 64'(want.sync));
            if (got.ack_ok != want.ack_ok)
                report("ack_ok", 64'(got.ack_ok), 64'(want.ack_ok));
            if (got.response_data != want.response_data)
                report("response_data", got.response_data, want.response_data);
        endtask
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   i_cfg_we      = 1'b0;
    logic [1:0]             i_cfg_wdata   = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_IN_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;
    logic [1:0]             m_axis_tuser;

    touch_report_board board;
    logic [7:0]        gen_type  = CH_TOUCH; // type the stimulus believes is expected
    bit                no_idle   = 1'b0;
    int                hold_len  = 0;

    touchscreen_serial_packet_decoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("simulation failed");
        $finish;
    end

    always @(posedge i_clk) begin : watch
        t_result  seen;
        t_request req;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                seen.event_kind    = m_axis_tuser;
                seen.has_xy        = m_axis_tdata[0];
                seen.x_pos         = m_axis_tdata[16:1];
                seen.y_pos         = m_axis_tdata[32:17];
                seen.has_pressure  = m_axis_tdata[33];
                seen.pressure      = m_axis_tdata[49:34];
                seen.has_touch     = m_axis_tdata[50];
                seen.touch         = m_axis_tdata[51];
                seen.sync          = m_axis_tdata[52];
                seen.ack_ok        = m_axis_tdata[53];
                seen.response_data = m_axis_tdata[117:54];
                board.check_result(seen);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                req.action       = s_axis_tuser;
                req.rx_byte      = s_axis_tdata[7:0];
                req.command_code = s_axis_tdata[15:8];
                board.note_request(req);
            end
        end
    end

    // result side: random stalls, or one long hold-off when asked
    initial begin : sink
        int stall;
        forever begin
            if (hold_len > 0) begin
                stall    = hold_len;
                hold_len = 0;
            end else begin
                stall = no_idle ? 0 : $urandom_range(0, 4);
            end
            repeat (stall) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge i_clk);
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_item(input logic act, input logic [7:0] rx, input logic [7:0] cmd);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {cmd, rx};
        s_axis_tuser  <= act;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_byte(input logic [7:0] b);
        logic [7:0] junk;
        junk = 8'($urandom);
        send_item(ACT_BYTE, b, junk);
    endtask

    task automatic issue_cmd(input logic [7:0] c);
        logic [7:0] junk;
        junk = 8'($urandom);
        send_item(ACT_COMMAND, junk, c);
        gen_type = (c >= CH_LOWER_A && c <= CH_LOWER_Z) ? c - CASE_GAP : c;
    endtask

    // first byte in the lowest bits
    task automatic send_seq(input logic [79:0] seq, input int n);
        for (int k = 0; k < n; k++) send_byte(seq[8*k +: 8]);
    endtask

    function automatic logic [7:0] pick_command();
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0:       c = CH_LOWER_A + 8'($urandom_range(0, 25));
            1:       c = CH_ACK + 8'($urandom_range(0, 25));
            2:       c = CH_TOUCH + CASE_GAP;
            3:       c = CH_ACK + CASE_GAP;
            4:       c = 8'($urandom);
            default: c = $urandom_range(0, 1) ? 8'hff : 8'h00;
        endcase
        return c;
    endfunction

    task automatic send_ten_frame(input logic [7:0] kind_byte, input logic [7:0] status,
                                  input bit bad_sum, input bit mid_cmd,
                                  input logic [47:0] body);
        logic [7:0] fb [PACKET_BYTES];
        logic [7:0] chk;
        logic [7:0] lower;
        int         cut;
        fb[0] = CH_LEAD;
        fb[1] = kind_byte;
        fb[2] = status;
        for (int k = 0; k < 6; k++) fb[3+k] = body[8*k +: 8];
        chk = CHK_SEED;
        for (int k = 0; k < PACKET_BYTES - 1; k++) chk = chk + fb[k];
        fb[9] = chk;
        if (bad_sum) fb[9] = fb[9] + 8'($urandom_range(1, 255));
        // a lower-case repeat of the current type must leave the frame intact
        lower = (gen_type >= CH_ACK && gen_type <= CH_UPPER_Z) ? gen_type + CASE_GAP
                                                               : gen_type;
        cut = mid_cmd ? $urandom_range(1, 8) : PACKET_BYTES;
        for (int k = 0; k < PACKET_BYTES; k++) begin
            if (k == cut) issue_cmd(lower);
            send_byte(fb[k]);
        end
    endtask

    task automatic ten_byte_round();
        int         pick;
        logic [7:0] st;
        logic [7:0] other;
        logic [47:0] body;
        pick = $urandom_range(0, 9);
        body = 48'({$urandom, $urandom});
        st   = 8'($urandom);
        if (pick <= 2) issue_cmd(pick_command());
        if (pick <= 7) begin
            if (gen_type == CH_ACK && $urandom_range(0, 3) != 0) st = CH_ZERO;
            send_ten_frame(gen_type, st, 1'b0, $urandom_range(0, 7) == 0, body);
            if (gen_type == CH_ACK)
                gen_type = (st == CH_ZERO) ? CH_TOUCH : CH_ACK;
            else if (gen_type != CH_TOUCH)
                gen_type = CH_ACK;
        end else if (pick == 8) begin
            send_ten_frame(gen_type, st, 1'b1, 1'b0, body);
        end else if ($urandom_range(0, 1)) begin
            other = gen_type ^ 8'($urandom_range(1, 255));
            send_ten_frame(other, st, 1'b0, 1'b0, body);
        end else begin
            repeat ($urandom_range(1, 5)) begin
                other = 8'($urandom);
                if (other == CH_LEAD) other = ~other;
                send_byte(other);
            end
        end
    endtask

    task automatic send_six_frame(input bit four);
        logic [7:0] fb [6];
        int         n;
        int         spoil;
        fb[0] = {2'b11, 6'($urandom)};
        fb[1] = {2'b10, 6'($urandom)};
        fb[2] = {2'b01, 6'($urandom)};
        fb[3] = {2'b00, 6'($urandom)};
        fb[4] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
        fb[5] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 15));
        n = four ? 4 : ((fb[4] != 0) ? 5 : 6);
        spoil = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n - 1) : -1;
        if (spoil >= 0) fb[spoil] = 8'($urandom);
        for (int k = 0; k < n; k++) send_byte(fb[k]);
    endtask

    task automatic send_three_frame(input bit clean);
        logic [7:0] b0;
        b0      = 8'($urandom);
        b0[6:0] = 7'h01;
        if (!clean && $urandom_range(0, 5) == 0) b0 = 8'($urandom);
        send_byte(b0);
        send_byte(8'($urandom));
        send_byte(8'($urandom));
    endtask

    // stop offering, wait out every due result and the pipeline
    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (board.due_reports.size() != 0) @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    task automatic set_format(input logic [1:0] p);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= p;
        board.set_format(p);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        board = new();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ten-byte format straight out of reset
        send_ten_frame(CH_TOUCH, 8'h83, 1'b0, 1'b0, {48{1'b1}});
        issue_cmd(CH_LOWER_Z);
        issue_cmd(8'hff);
        issue_cmd(8'h00);
        issue_cmd(CH_TOUCH + CASE_GAP);
        for (int i = 0; i < 12; i++) begin
            no_idle = (i % 8) < 2;
            ten_byte_round();
        end
        no_idle = 1'b0;

        set_format(PROTO_THREE);
        send_seq(80'hff_80_81, 3);
        send_seq(80'h00_00_01, 3);
        for (int i = 0; i < 20; i++) begin
            no_idle = (i % 8) < 2;
            if ($urandom_range(0, 9) == 0) issue_cmd(pick_command());
            send_three_frame(1'b0);
        end
        // long output stall with the input kept busy, then a full drain
        no_idle  = 1'b1;
        hold_len = HOLD_LONG;
        for (int i = 0; i < 20; i++) send_three_frame(1'b1);
        no_idle = 1'b0;
        settle();
        for (int i = 0; i < 6; i++) send_three_frame(1'b0);
        send_byte(8'h01); // frame cut short by the format change

        set_format(PROTO_SIX);
        send_seq(80'h0f_00_3f_7f_bf_ff, 6);
        send_seq(80'hff_00_40_80_c0, 5);
        for (int i = 0; i < 20; i++) begin
            no_idle = (i % 8) < 2;
            send_six_frame(1'b0);
        end
        no_idle = 1'b0;
        send_seq(80'h80_c0, 2);

        set_format(PROTO_FOUR);
        send_seq(80'h00_40_80_c0, 4);
        for (int i = 0; i < 20; i++) begin
            no_idle = (i % 8) < 2;
            if ($urandom_range(0, 9) == 0) issue_cmd(pick_command());
            send_six_frame(1'b1);
        end
        no_idle = 1'b0;

        set_format(PROTO_TEN);
        for (int i = 0; i < 8; i++) begin
            no_idle = (i % 8) < 2;
            ten_byte_round();
        end
        no_idle = 1'b0;

        settle();
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
sv/tspd_pkg.sv
sv/tspd_in_reg.sv
sv/tspd_decode.sv
sv/tspd_out_reg.sv
sv/touchscreen_serial_packet_decoder_top.sv
verif/touchscreen_serial_packet_decoder_top_tb.sv
